### hdl/flbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow layout box placer package
// Shared types, register indexes, mode and action codes, saturation helpers.
// ----------------------------------------------------------------------------
package flbp_pkg;

	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 16;
	localparam int unsigned InDataW  = 48;
	localparam int unsigned OutDataW = 64;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] REG_ORIGIN_X    = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_ORIGIN_Y    = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_AREA_WIDTH  = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_AREA_HEIGHT = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_PADDING     = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_MODE        = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_TITLE       = 3'd6;

	typedef enum logic [1:0] {
		MODE_NONE  = 2'd0,
		MODE_FILL  = 2'd1,
		MODE_ROWS  = 2'd2,
		MODE_BLOCK = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ACT_PLACED    = 2'd0,
		ACT_HIDDEN    = 2'd1,
		ACT_SHOWN     = 2'd2,
		ACT_UNTOUCHED = 2'd3
	} action_t;

	typedef struct packed {
		logic signed [15:0] origin_x;
		logic signed [15:0] origin_y;
		logic [13:0]        area_w;
		logic [13:0]        area_h;
		logic [7:0]         pad;
		mode_t              mode;
		logic [9:0]         title;
	} cfg_t;

	// one sized child on its way to the layout stage
	typedef struct packed {
		logic               first;
		logic signed [15:0] w;
		logic signed [15:0] h;
	} item_t;

	// usable height: container height less the title band, may go negative
	function automatic logic signed [14:0] usable_h(input cfg_t c);
		return $signed({1'b0, c.area_h}) - $signed({5'b0, c.title});
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
		logic signed [15:0] r;
		if (v > 20'sd32767) r = 16'sh7FFF;
		else if (v < -20'sd32768) r = 16'sh8000;
		else r = v[15:0];
		return r;
	endfunction

	function automatic logic signed [17:0] sat18(input logic signed [19:0] v);
		logic signed [17:0] r;
		if (v > 20'sd131071) r = 18'sh1FFFF;
		else if (v < -20'sd131072) r = 18'sh20000;
		else r = v[17:0];
		return r;
	endfunction

endpackage

### hdl/flbp_size.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Percent sizing pipeline
// Two stages: form pct*full - 200*pad, then divide by 100 toward zero.
// ----------------------------------------------------------------------------
module flbp_size (
	input  logic                        clk,
	input  logic                        arst_n,
	input  flbp_pkg::cfg_t              cfg,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        in_first,
	input  logic                        in_pct_mode,
	input  logic [14:0]                 in_width,
	input  logic [14:0]                 in_height,
	input  logic [6:0]                  in_pct_x,
	input  logic [6:0]                  in_pct_y,
	output logic                        out_valid,
	input  logic                        out_ready,
	output flbp_pkg::item_t             out_item
);
	import flbp_pkg::*;

	// ceil(2^28 / 100); exact floor division for magnitudes below 2^21
	localparam logic [21:0] Recip      = 22'd2684355;
	localparam int unsigned RecipShift = 28;

	function automatic logic signed [15:0] div100(input logic signed [22:0] n);
		logic        neg;
		logic [22:0] mag;
		logic [42:0] prod;
		logic [15:0] q;
		neg  = n[22];
		mag  = neg ? 23'(-n) : 23'(n);
		prod = 43'(mag[20:0]) * 43'(Recip);
		q    = {1'b0, prod[RecipShift +: 15]};
		return neg ? -$signed(q) : $signed(q);
	endfunction

	logic               vld_s1, vld_s2;
	logic               rdy_s1, rdy_s2;
	logic signed [22:0] num_x_s1, num_y_s1;
	logic               use_x_s1, use_y_s1, first_s1;
	logic [14:0]        w_s1, h_s1;
	logic [15:0]        pad200;
	logic [20:0]        prod_x;
	logic signed [22:0] prod_y;
	logic signed [14:0] hgt;

	assign hgt    = usable_h(cfg);
	assign pad200 = 16'(cfg.pad) * 16'd200;
	assign prod_x = 21'(in_pct_x) * 21'(cfg.area_w);
	assign prod_y = $signed({16'b0, in_pct_y}) * $signed({{8{hgt[14]}}, hgt});

	assign rdy_s2   = !vld_s2 || out_ready;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign in_ready = rdy_s1;
	assign out_valid = vld_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= in_valid;
			if (rdy_s2) vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy_s1) begin
			num_x_s1 <= $signed({2'b0, prod_x}) - $signed({7'b0, pad200});
			num_y_s1 <= prod_y - $signed({7'b0, pad200});
			use_x_s1 <= in_pct_mode && (in_pct_x != 7'd0);
			use_y_s1 <= in_pct_mode && (in_pct_y != 7'd0);
			w_s1     <= in_width;
			h_s1     <= in_height;
			first_s1 <= in_first;
		end
		if (vld_s1 && rdy_s2) begin
			out_item.first <= first_s1;
			out_item.w     <= use_x_s1 ? div100(num_x_s1) : $signed({1'b0, w_s1});
			out_item.h     <= use_y_s1 ? div100(num_y_s1) : $signed({1'b0, h_s1});
		end
	end

endmodule

### hdl/flbp_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Layout stage
// Cursor state, placement decision and the result register.
// ----------------------------------------------------------------------------
module flbp_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  flbp_pkg::cfg_t              cfg,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  flbp_pkg::item_t             item,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [flbp_pkg::OutDataW-1:0] m_tdata,
	output logic [1:0]                  m_tuser
);
	import flbp_pkg::*;

	logic signed [17:0] cur_x_q, cur_y_q;
	logic [15:0]        row_max_q;
	logic               hide_q, fill_q;
	logic               out_vld_q;
	action_t            act_q;
	logic signed [15:0] bx_q, by_q, bw_q, bh_q;

	logic               fire;
	logic signed [17:0] cx, cy;
	logic [15:0]        rt, rt_use, rt_new;
	logic               hide, fill;
	logic signed [14:0] hgt;
	logic signed [19:0] cx20, cy20, w20, h20, p20, p2, ox20, top20, aw20, hgt20;
	logic signed [19:0] cx_use, cy_use, cy_wrap20;
	logic               hidden, wrap;
	logic signed [17:0] cy_wrap;
	logic signed [17:0] nx_cur_x, nx_cur_y;
	logic [15:0]        nx_row;
	logic               nx_hide, nx_fill;
	action_t            act;
	logic signed [19:0] bx, by, bw, bh;

	assign in_ready = !out_vld_q || m_tready;
	assign fire     = in_valid && in_ready;

	always_comb begin
		// a first item starts the pass from cleared state
		cx   = item.first ? '0 : cur_x_q;
		cy   = item.first ? '0 : cur_y_q;
		rt   = item.first ? '0 : row_max_q;
		hide = item.first ? 1'b0 : hide_q;
		fill = item.first ? 1'b0 : fill_q;

		hgt   = usable_h(cfg);
		cx20  = {{2{cx[17]}}, cx};
		cy20  = {{2{cy[17]}}, cy};
		w20   = {{4{item.w[15]}}, item.w};
		h20   = {{4{item.h[15]}}, item.h};
		p20   = {12'b0, cfg.pad};
		p2    = {11'b0, cfg.pad, 1'b0};
		ox20  = {{4{cfg.origin_x[15]}}, cfg.origin_x};
		top20 = {{4{cfg.origin_y[15]}}, cfg.origin_y} + {10'b0, cfg.title};
		aw20  = {6'b0, cfg.area_w};
		hgt20 = {{5{hgt[14]}}, hgt};

		hidden    = cy20 >= hgt20;
		wrap      = (cx20 + w20 + p20) >= aw20;
		cy_wrap   = sat18(cy20 + $signed({4'b0, rt}) + p2);
		cy_wrap20 = {{2{cy_wrap[17]}}, cy_wrap};
		cx_use    = wrap ? '0 : cx20;
		cy_use    = wrap ? cy_wrap20 : cy20;
		rt_use    = wrap ? '0 : rt;
		rt_new    = (h20 > $signed({4'b0, rt_use})) ? item.h[15:0] : rt_use;

		nx_cur_x = cx;
		nx_cur_y = cy;
		nx_row   = rt;
		nx_hide  = hide;
		nx_fill  = fill;
		act      = hide ? ACT_HIDDEN : ACT_PLACED;
		bx       = '0;
		by       = '0;
		bw       = '0;
		bh       = '0;

		case (cfg.mode)
			MODE_FILL: begin
				if (fill) begin
					act = ACT_UNTOUCHED;
				end else begin
					bx      = ox20 + p20;
					by      = top20 + p20;
					bw      = aw20 - p2;
					bh      = hgt20 - p2;
					nx_fill = 1'b1;
				end
			end
			MODE_ROWS: begin
				if (hidden) begin
					nx_hide = 1'b1;
					act     = ACT_HIDDEN;
				end else begin
					bx       = ox20 + p20 + cx20;
					by       = top20 + p20 + cy20;
					bw       = w20;
					bh       = h20;
					nx_cur_y = sat18(cy20 + h20 + p2);
				end
			end
			MODE_BLOCK: begin
				if (hidden) begin
					nx_hide = 1'b1;
					act     = ACT_HIDDEN;
				end else begin
					bx       = ox20 + p20 + cx_use;
					by       = top20 + p20 + cy_use;
					bw       = w20;
					bh       = h20;
					nx_cur_x = sat18(cx_use + w20 + p2);
					nx_cur_y = cy_use[17:0];
					nx_row   = rt_new;
				end
			end
			default: begin
				act = hide ? ACT_HIDDEN : ACT_SHOWN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q   <= '0;
			cur_y_q   <= '0;
			row_max_q <= '0;
			hide_q    <= 1'b0;
			fill_q    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (in_ready) out_vld_q <= in_valid;
			if (fire) begin
				cur_x_q   <= nx_cur_x;
				cur_y_q   <= nx_cur_y;
				row_max_q <= nx_row;
				hide_q    <= nx_hide;
				fill_q    <= nx_fill;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			act_q <= act;
			bx_q  <= sat16(bx);
			by_q  <= sat16(by);
			bw_q  <= sat16(bw);
			bh_q  <= sat16(bh);
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {bh_q, bw_q, by_q, bx_q};
	assign m_tuser  = act_q;

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(cur_x_q) && $stable(cur_y_q) && $stable(row_max_q) && $stable(hide_q))
		else $error("layout state changed without an item");

	a_hide_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		fire && hide_q && !item.first |=> hide_q)
		else $error("hide latch dropped inside a pass");

	a_fill_once: assert property (@(posedge clk) disable iff (!arst_n)
		fire && cfg.mode == MODE_FILL && fill_q && !item.first |=> m_tuser == ACT_UNTOUCHED)
		else $error("fill mode placed a second child");

	a_fill_sets: assert property (@(posedge clk) disable iff (!arst_n)
		fire && cfg.mode == MODE_FILL |=> fill_q)
		else $error("fill flag not set after a fill placement");

endmodule

### hdl/flow_layout_box_placer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow layout box placer
// Places the child boxes of one container, one child per item.
// ----------------------------------------------------------------------------
// Usage:
//   Program the container through cfg_wen/cfg_idx/cfg_data while no item is
//   in flight, then stream children on the s_ channel. Set s_tuser[0] on the
//   first child of each layout pass to clear the cursors, the row height, the
//   hide latch and the fill flag. Each child yields exactly one result on the
//   m_ channel: m_tuser carries the action code, m_tdata the placed box.
// Timing:
//   Three register stages (percent product, divide by 100, layout and result
//   register). m_tvalid rises when the result register takes the item. One
//   item is accepted per cycle while the output is not stalled, and the
//   cursor update closes within the layout stage, so back-to-back children
//   of one pass never wait on each other.
// Reset:
//   arst_n clears every configuration register, the cursors and all valid
//   flags; the pipeline comes up empty and ready.
// Back-pressure:
//   When m_tready is low the result register holds and each earlier stage
//   keeps taking items until it is full; s_tready falls only then.
// ----------------------------------------------------------------------------
module flow_layout_box_placer (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write port
	input  logic                              cfg_wen,
	input  logic [flbp_pkg::CfgIdxW-1:0]      cfg_idx,
	input  logic [flbp_pkg::CfgDataW-1:0]     cfg_data,
	// child stream in
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// item_width[14:0], item_height[29:15], percent_x[36:30],
	// percent_y[43:37], zero fill [47:44]
	input  logic [flbp_pkg::InDataW-1:0]      s_tdata,
	// first_item[0], percent_mode[1]
	input  logic [1:0]                        s_tuser,
	// placed box out
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// box_x[15:0], box_y[31:16], box_w[47:32], box_h[63:48]
	output logic [flbp_pkg::OutDataW-1:0]     m_tdata,
	// action[1:0]
	output logic [1:0]                        m_tuser
);
	import flbp_pkg::*;

	cfg_t  cfg_q;
	logic  item_vld;
	logic  item_rdy;
	item_t item;

	// hold configuration; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{origin_x: '0, origin_y: '0, area_w: '0, area_h: '0,
			           pad: '0, mode: MODE_NONE, title: '0};
		end else if (cfg_wen) begin
			case (cfg_idx)
				REG_ORIGIN_X:    cfg_q.origin_x <= $signed(cfg_data);
				REG_ORIGIN_Y:    cfg_q.origin_y <= $signed(cfg_data);
				REG_AREA_WIDTH:  cfg_q.area_w   <= cfg_data[13:0];
				REG_AREA_HEIGHT: cfg_q.area_h   <= cfg_data[13:0];
				REG_PADDING:     cfg_q.pad      <= cfg_data[7:0];
				REG_MODE:        cfg_q.mode     <= mode_t'(cfg_data[1:0]);
				REG_TITLE:       cfg_q.title    <= cfg_data[9:0];
				default: begin
				end
			endcase
		end
	end

	// percent sizing: product stage and divide stage
	flbp_size u_size (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_first    (s_tuser[0]),
		.in_pct_mode (s_tuser[1]),
		.in_width    (s_tdata[14:0]),
		.in_height   (s_tdata[29:15]),
		.in_pct_x    (s_tdata[36:30]),
		.in_pct_y    (s_tdata[43:37]),
		.out_valid   (item_vld),
		.out_ready   (item_rdy),
		.out_item    (item)
	);

	// cursor state, placement and result register
	flbp_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (item_vld),
		.in_ready (item_rdy),
		.item     (item),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

### tb/flow_layout_box_placer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow layout box placer testbench
// Programs containers through the register port, streams children in passes
// and checks every placed box against a built-in layout predictor. Directed
// passes cover each placement mode and its corner cases. Random passes follow
// and run under three idling patterns. One long output stall fills the
// pipeline so that the input must back up.
// ----------------------------------------------------------------------------
module flow_layout_box_placer_test;
	import flbp_pkg::*;

	// one child as it travels on the input stream
	typedef struct packed {
		logic        first;
		logic [14:0] width;
		logic [14:0] height;
		logic        by_pct;
		logic [6:0]  pct_x;
		logic [6:0]  pct_y;
	} child_t;

	// one placed box as it should leave the block
	typedef struct packed {
		action_t     act;
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] w;
		logic [15:0] h;
	} box_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_wen;
	logic [CfgIdxW-1:0]  cfg_idx;
	logic [CfgDataW-1:0] cfg_data;
	logic                s_tvalid;
	logic                s_tready;
	logic [InDataW-1:0]  s_tdata;
	logic [1:0]          s_tuser;
	logic                m_tvalid;
	logic                m_tready;
	logic [OutDataW-1:0] m_tdata;
	logic [1:0]          m_tuser;

	// container copy held by the predictor, written along with the block
	longint cont_ox    = 0;
	longint cont_oy    = 0;
	longint cont_w     = 0;
	longint cont_h     = 0;
	longint cont_pad   = 0;
	longint cont_title = 0;
	mode_t  cont_mode  = MODE_NONE;

	// layout state of the pass in progress
	longint pen_x      = 0;
	longint pen_y      = 0;
	longint row_peak   = 0;
	logic   hide_on    = 1'b0;
	logic   fill_taken = 1'b0;

	box_t boxes_due[$];
	box_t want;
	int   errors        = 0;
	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	int   hold_left     = 0;

	flow_layout_box_placer i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hard stop: far beyond the slowest legal run.
	initial begin
		#5000000;
		$display("flow_layout_box_placer_test NOT OK");
		$finish;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	function automatic logic [15:0] clip16(input longint v);
		if (v > 32767) return 16'h7FFF;
		if (v < -32768) return 16'h8000;
		return v[15:0];
	endfunction

	// cursors are 18-bit signed and stick at their limits
	function automatic longint clip_cursor(input longint v);
		if (v > 131071) return 131071;
		if (v < -131072) return -131072;
		return v;
	endfunction

	// percent of the container less padding on both sides, truncated to zero
	function automatic longint scale_pct(input longint pct, input longint full,
			input longint pad);
		return (pct * full - 200 * pad) / 100;
	endfunction

	// Place one child; updates the pass state and returns the expected box.
	function automatic box_t place_child(input child_t c);
		longint  w, h, px, py, top, usable;
		longint  bx, by, bw, bh;
		action_t act;
		box_t    r;
		w      = longint'(c.width);
		h      = longint'(c.height);
		px     = longint'(c.pct_x);
		py     = longint'(c.pct_y);
		top    = cont_oy + cont_title;
		usable = cont_h - cont_title;
		bx = 0;
		by = 0;
		bw = 0;
		bh = 0;
		if (c.first) begin
			pen_x      = 0;
			pen_y      = 0;
			row_peak   = 0;
			hide_on    = 1'b0;
			fill_taken = 1'b0;
		end
		if (c.by_pct) begin
			if (px != 0) w = scale_pct(px, cont_w, cont_pad);
			if (py != 0) h = scale_pct(py, usable, cont_pad);
		end
		case (cont_mode)
			MODE_FILL: begin
				if (fill_taken) begin
					act = ACT_UNTOUCHED;
				end else begin
					bx = cont_ox + cont_pad;
					by = top + cont_pad;
					bw = cont_w - 2 * cont_pad;
					bh = usable - 2 * cont_pad;
					fill_taken = 1'b1;
					act = hide_on ? ACT_HIDDEN : ACT_PLACED;
				end
			end
			MODE_ROWS: begin
				if (pen_y >= usable) begin
					hide_on = 1'b1;
					act = ACT_HIDDEN;
				end else begin
					bx = cont_ox + cont_pad + pen_x;
					by = top + cont_pad + pen_y;
					bw = w;
					bh = h;
					pen_y = clip_cursor(pen_y + h + 2 * cont_pad);
					act = hide_on ? ACT_HIDDEN : ACT_PLACED;
				end
			end
			MODE_BLOCK: begin
				if (pen_y >= usable) begin
					hide_on = 1'b1;
					act = ACT_HIDDEN;
				end else begin
					// wrap before placing when this child would cross the right edge
					if (pen_x + w + cont_pad >= cont_w) begin
						pen_x = 0;
						pen_y = clip_cursor(pen_y + row_peak + 2 * cont_pad);
						row_peak = 0;
					end
					if (h > row_peak) row_peak = (h > 65535) ? 65535 : h;
					bx = cont_ox + cont_pad + pen_x;
					by = top + cont_pad + pen_y;
					bw = w;
					bh = h;
					pen_x = clip_cursor(pen_x + w + 2 * cont_pad);
					act = hide_on ? ACT_HIDDEN : ACT_PLACED;
				end
			end
			default: begin
				act = hide_on ? ACT_HIDDEN : ACT_SHOWN;
			end
		endcase
		r.act = act;
		r.x   = clip16(bx);
		r.y   = clip16(by);
		r.w   = clip16(bw);
		r.h   = clip16(bh);
		return r;
	endfunction

	function automatic child_t child(input logic first, input logic [14:0] w,
			input logic [14:0] h, input logic by_pct, input logic [6:0] px,
			input logic [6:0] py);
		child_t c;
		c.first  = first;
		c.width  = w;
		c.height = h;
		c.by_pct = by_pct;
		c.pct_x  = px;
		c.pct_y  = py;
		return c;
	endfunction

	// ------------------------------------------------------------------
	// Stream drivers
	// ------------------------------------------------------------------

	// Offer one child, idling the sender for each cycle that draws an idle,
	// and record its box once the block takes it. Valid stays high between
	// back-to-back items.
	task automatic send_child(input child_t c);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct) gap++;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata  = {4'b0, c.pct_y, c.pct_x, c.height, c.width};
		s_tuser  = {c.by_pct, c.first};
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		boxes_due.push_back(place_child(c));
	endtask

	// Drop valid, wait for every outstanding box, then let the pipe run dry.
	task automatic settle();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (boxes_due.size() != 0) @(negedge clk);
		repeat (5) @(negedge clk);
	endtask

	// Registers change only with the block idle.
	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] data);
		settle();
		cfg_wen  = 1'b1;
		cfg_idx  = idx;
		cfg_data = data;
		case (idx)
			REG_ORIGIN_X:    cont_ox    = longint'($signed(data));
			REG_ORIGIN_Y:    cont_oy    = longint'($signed(data));
			REG_AREA_WIDTH:  cont_w     = longint'(data[13:0]);
			REG_AREA_HEIGHT: cont_h     = longint'(data[13:0]);
			REG_PADDING:     cont_pad   = longint'(data[7:0]);
			REG_MODE:        cont_mode  = mode_t'(data[1:0]);
			REG_TITLE:       cont_title = longint'(data[9:0]);
			default: ;
		endcase
		@(negedge clk);
		cfg_wen = 1'b0;
	endtask

	task automatic set_container(input logic [15:0] ox, input logic [15:0] oy,
			input logic [13:0] w, input logic [13:0] h, input logic [7:0] pad,
			input mode_t mode, input logic [9:0] title);
		write_reg(REG_ORIGIN_X, ox);
		write_reg(REG_ORIGIN_Y, oy);
		write_reg(REG_AREA_WIDTH, {2'b0, w});
		write_reg(REG_AREA_HEIGHT, {2'b0, h});
		write_reg(REG_PADDING, {8'b0, pad});
		write_reg(REG_MODE, {14'b0, mode});
		write_reg(REG_TITLE, {6'b0, title});
	endtask

	// Result side: random stalls, or a counted hold-off when one is armed.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				m_tready = 1'b0;
				hold_left--;
			end else begin
				m_tready = ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Compare every accepted box with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (boxes_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected box act=%0d data=%h", $time, m_tuser, m_tdata);
			end else begin
				want = boxes_due.pop_front();
				if ({m_tuser, m_tdata} !== {want.act, want.h, want.w, want.y, want.x}) begin
					errors++;
					$display("%0t: box mismatch expected act=%0d x=%0d y=%0d w=%0d h=%0d",
						$time, want.act, $signed(want.x), $signed(want.y),
						$signed(want.w), $signed(want.h));
					$display("%0t:              actual   act=%0d x=%0d y=%0d w=%0d h=%0d",
						$time, m_tuser, $signed(m_tdata[15:0]), $signed(m_tdata[31:16]),
						$signed(m_tdata[47:32]), $signed(m_tdata[63:48]));
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Out of reset every register is zero: mode none keeps each box as it is.
	task automatic test_reset_state();
		send_child(child(1'b1, 15'h7FFF, 15'h0000, 1'b0, 7'd0, 7'd0));
		send_child(child(1'b0, 15'h0000, 15'h7FFF, 1'b1, 7'd100, 7'd100));
	endtask

	// Fill: first child takes the padded area, the rest stay untouched.
	// Extreme origins drive the box fields into saturation.
	task automatic test_fill_mode();
		set_container(16'h7FFF, 16'h8000, 14'h3FFF, 14'h3FFF, 8'hFF, MODE_FILL, 10'h3FF);
		send_child(child(1'b1, 15'd10, 15'd10, 1'b0, 7'd0, 7'd0));
		send_child(child(1'b0, 15'd10, 15'd10, 1'b0, 7'd0, 7'd0));
		send_child(child(1'b1, 15'd10, 15'd10, 1'b0, 7'd0, 7'd0));
		// empty container: padding drives width and height negative
		set_container(16'h8000, 16'h7FFF, 14'd0, 14'd0, 8'hFF, MODE_FILL, 10'd0);
		send_child(child(1'b1, 15'd0, 15'd0, 1'b0, 7'd0, 7'd0));
	endtask

	// Rows: stack until the cursor passes the bottom, then hide.
	task automatic test_rows_mode();
		set_container(16'd0, 16'd0, 14'd100, 14'd200, 8'd2, MODE_ROWS, 10'd50);
		send_child(child(1'b1, 15'd40, 15'd60, 1'b0, 7'd0, 7'd0));
		send_child(child(1'b0, 15'd40, 15'd60, 1'b0, 7'd0, 7'd0));
		send_child(child(1'b0, 15'd40, 15'd60, 1'b0, 7'd0, 7'd0));
		send_child(child(1'b0, 15'd40, 15'd60, 1'b0, 7'd0, 7'd0));
		send_child(child(1'b0, 15'd40, 15'd60, 1'b0, 7'd0, 7'd0));
		// title taller than the container: usable height is negative
		write_reg(REG_TITLE, 16'd300);
		send_child(child(1'b1, 15'd1, 15'd1, 1'b0, 7'd0, 7'd0));
	endtask

	// Block flow: fill a row, wrap below the tallest box, then an oversize child.
	task automatic test_block_mode();
		set_container(16'd10, 16'd20, 14'd100, 14'd500, 8'd1, MODE_BLOCK, 10'd0);
		send_child(child(1'b1, 15'd30, 15'd10, 1'b0, 7'd0, 7'd0));
		send_child(child(1'b0, 15'd30, 15'd25, 1'b0, 7'd0, 7'd0));
		send_child(child(1'b0, 15'd30, 15'd5, 1'b0, 7'd0, 7'd0));
		send_child(child(1'b0, 15'd10, 15'd7, 1'b0, 7'd0, 7'd0));
		send_child(child(1'b0, 15'h7FFF, 15'h7FFF, 1'b0, 7'd0, 7'd0));
	endtask

	// Percent sizing: full, zero keeps the size, out-of-range percents,
	// percent flag off, and negative sizes from an empty container.
	task automatic test_percent_sizes();
		set_container(16'd0, 16'd0, 14'h3FFF, 14'h3FFF, 8'hFF, MODE_ROWS, 10'h3FF);
		send_child(child(1'b1, 15'd5, 15'd5, 1'b1, 7'd100, 7'd100));
		send_child(child(1'b0, 15'd77, 15'd5, 1'b1, 7'd0, 7'd1));
		send_child(child(1'b0, 15'd5, 15'd5, 1'b1, 7'd127, 7'd127));
		send_child(child(1'b0, 15'd9, 15'd9, 1'b0, 7'd50, 7'd50));
		set_container(16'd0, 16'd0, 14'd0, 14'd100, 8'hFF, MODE_BLOCK, 10'd0);
		send_child(child(1'b1, 15'd5, 15'd5, 1'b1, 7'd1, 7'd3));
	endtask

	// Switch modes inside one pass; the hide latch carries over.
	task automatic test_mode_switch();
		set_container(16'd0, 16'd0, 14'd100, 14'd100, 8'd0, MODE_ROWS, 10'd0);
		send_child(child(1'b1, 15'd20, 15'd200, 1'b0, 7'd0, 7'd0));
		send_child(child(1'b0, 15'd20, 15'd20, 1'b0, 7'd0, 7'd0));
		write_reg(REG_MODE, {14'b0, MODE_FILL});
		send_child(child(1'b0, 15'd20, 15'd20, 1'b0, 7'd0, 7'd0));
		write_reg(REG_MODE, {14'b0, MODE_NONE});
		send_child(child(1'b0, 15'd20, 15'd20, 1'b0, 7'd0, 7'd0));
		write_reg(REG_MODE, {14'b0, MODE_BLOCK});
		send_child(child(1'b0, 15'd20, 15'd20, 1'b0, 7'd0, 7'd0));
	endtask

	// Pick one child sized against the current container, with rare extremes.
	function automatic child_t random_child(input logic first);
		child_t c;
		c.first = first | ($urandom_range(99) < 3);
		case ($urandom_range(9))
			0:       c.width = 15'd0;
			1:       c.width = 15'h7FFF;
			2:       c.width = 15'($urandom);
			default: c.width = 15'($urandom_range(0, int'(cont_w / 3) + 2));
		endcase
		case ($urandom_range(9))
			0:       c.height = 15'd0;
			1:       c.height = 15'h7FFF;
			2:       c.height = 15'($urandom);
			default: c.height = 15'($urandom_range(0, int'(cont_h / 4) + 2));
		endcase
		c.by_pct = ($urandom_range(3) == 0);
		case ($urandom_range(7))
			0:       c.pct_x = 7'd0;
			1:       c.pct_x = 7'd100;
			2:       c.pct_x = 7'($urandom_range(0, 127));
			default: c.pct_x = 7'($urandom_range(1, 50));
		endcase
		case ($urandom_range(7))
			0:       c.pct_y = 7'd0;
			1:       c.pct_y = 7'd100;
			2:       c.pct_y = 7'($urandom_range(0, 127));
			default: c.pct_y = 7'($urandom_range(1, 50));
		endcase
		return c;
	endfunction

	// Reprogram the container: mostly modest layouts, sometimes the limits.
	task automatic random_container();
		logic [15:0] ox, oy;
		logic [13:0] w, h;
		logic [7:0]  pad;
		logic [9:0]  title;
		mode_t       mode;
		case ($urandom_range(9))
			0:       ox = 16'h8000;
			1:       ox = 16'h7FFF;
			2, 3:    ox = 16'($urandom);
			default: ox = 16'($urandom_range(0, 2000) - 1000);
		endcase
		case ($urandom_range(9))
			0:       oy = 16'h8000;
			1:       oy = 16'h7FFF;
			2, 3:    oy = 16'($urandom);
			default: oy = 16'($urandom_range(0, 2000) - 1000);
		endcase
		case ($urandom_range(9))
			0:       w = 14'd0;
			1:       w = 14'h3FFF;
			2:       w = 14'($urandom);
			default: w = 14'($urandom_range(20, 600));
		endcase
		case ($urandom_range(9))
			0:       h = 14'd0;
			1:       h = 14'h3FFF;
			2:       h = 14'($urandom);
			default: h = 14'($urandom_range(20, 600));
		endcase
		case ($urandom_range(9))
			0:       pad = 8'hFF;
			1:       pad = 8'd0;
			default: pad = 8'($urandom_range(0, 12));
		endcase
		case ($urandom_range(9))
			0:       title = 10'h3FF;
			1:       title = 10'd0;
			2:       title = 10'($urandom);
			default: title = 10'($urandom_range(0, 40));
		endcase
		case ($urandom_range(9))
			0:             mode = MODE_NONE;
			1:             mode = MODE_FILL;
			2, 3, 4, 5:    mode = MODE_ROWS;
			default:       mode = MODE_BLOCK;
		endcase
		set_container(ox, oy, w, h, pad, mode, title);
	endtask

	// Hold the result side off long enough for the pipe to fill and the
	// input to stall, while children keep coming.
	task automatic test_output_stall();
		set_container(16'd0, 16'd0, 14'd300, 14'd2000, 8'd3, MODE_BLOCK, 10'd16);
		send_idle_pct = 0;
		@(posedge clk);
		hold_left = 60;
		for (int i = 0; i < 24; i++) send_child(random_child(i == 0));
	endtask

	// Well-formed passes with random content under one idling pattern.
	task automatic test_random_passes(input int send_pct, input int recv_pct,
			input int count);
		int sent;
		int n;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		sent = 0;
		while (sent < count) begin
			random_container();
			n = $urandom_range(1, 14);
			for (int i = 0; i < n; i++) send_child(random_child(i == 0));
			sent += n;
		end
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n   = 1'b0;
		cfg_wen  = 1'b0;
		cfg_idx  = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 24;
		recv_idle_pct = 64;
		test_reset_state();
		test_fill_mode();
		test_rows_mode();
		test_block_mode();
		test_percent_sizes();
		test_mode_switch();
		test_output_stall();

		test_random_passes(24, 64, 410);
		test_random_passes(64, 24, 410);
		test_random_passes(0, 0, 410);

		// drain and give the pipe time to show any stray box
		settle();
		repeat (10) @(posedge clk);
		if (errors == 0) begin
			$display("flow_layout_box_placer_test OK");
		end else begin
			$display("flow_layout_box_placer_test NOT OK");
		end
		$finish;
	end

endmodule
